>>> rtl/pfms_pkg.sv
// Shared constants for the packed frame scan-out block.
// Used by pfms_front, pfms_queue, pfms_back and packed_frame_mode_scanout.
`default_nettype none

package pfms_pkg;

    localparam int FRAME_SIDE_DEF = 128;
    localparam int Q_DEPTH        = 2;

    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 8;
    localparam int PIX_W   = 7;
    localparam int INDEX_W = 4;
    localparam int MODE_W  = 8;

    // beat kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // screen modes
    localparam logic [MODE_W-1:0] MODE_STRETCH_X  = 8'd1;
    localparam logic [MODE_W-1:0] MODE_STRETCH_Y  = 8'd2;
    localparam logic [MODE_W-1:0] MODE_STRETCH_XY = 8'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR_X   = 8'd5;
    localparam logic [MODE_W-1:0] MODE_MIRROR_Y   = 8'd6;
    localparam logic [MODE_W-1:0] MODE_MIRROR_XY  = 8'd7;

endpackage

`default_nettype wire

>>> rtl/pfms_front.sv
// Front end: takes command beats, holds the screen mode register, maps
// pixel coordinates to a store address. Depends on pfms_pkg.
`default_nettype none

module pfms_front #(
    parameter int FRAME_SIDE = pfms_pkg::FRAME_SIDE_DEF,
    parameter int AW         = $clog2(FRAME_SIDE * (FRAME_SIDE / 2)),
    parameter int PW         = AW + pfms_pkg::DATA_W + 2
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    output logic                            o_busy,
    input  wire                             i_mode,
    input  wire  [pfms_pkg::ADDR_W-1:0]     i_byte_addr,
    input  wire  [pfms_pkg::DATA_W-1:0]     i_byte_data,
    input  wire  [pfms_pkg::PIX_W-1:0]      i_pixel_x,
    input  wire  [pfms_pkg::PIX_W-1:0]      i_pixel_y,
    input  wire                             i_cfg_we,
    input  wire  [pfms_pkg::MODE_W-1:0]     i_cfg_data,
    output logic                            o_push_valid,
    output logic [PW-1:0]                   o_push_data,
    input  wire                             i_push_ready
);

    localparam int HALF  = FRAME_SIDE / 2;
    localparam int DEPTH = FRAME_SIDE * HALF;
    localparam int CW    = $clog2(FRAME_SIDE);
    localparam int RW    = CW + 4;
    localparam logic [CW-1:0] HALF_C = CW'(HALF);
    localparam logic [CW-1:0] LAST_C = CW'(FRAME_SIDE - 1);

    logic [pfms_pkg::MODE_W-1:0] r_screen_mode;
    logic                        r_valid;
    logic [PW-1:0]               r_cmd;
    logic [PW-1:0]               n_cmd;

    logic            advance;
    logic            accept;
    logic            wr_ok;
    logic [CW-1:0]   cx, cy, sx, sy;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    function automatic logic [CW-1:0] wrap_coord(input logic [pfms_pkg::PIX_W-1:0] c);
        logic [RW-1:0] t;
        t = RW'(c);
        for (int k = 2; k >= 0; k--) begin
            if (t >= (RW'(FRAME_SIDE) << k)) begin
                t = t - (RW'(FRAME_SIDE) << k);
            end
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] mirror_coord(input logic [CW-1:0] c);
        return (c < HALF_C) ? c : (LAST_C - c);
    endfunction

    assign advance = !r_valid || i_push_ready;
    assign o_busy  = !advance;
    assign accept  = i_start && advance;
    assign wr_ok   = 32'(i_byte_addr) < 32'(DEPTH);

    always_comb begin
        cx = wrap_coord(i_pixel_x);
        cy = wrap_coord(i_pixel_y);
        sx = cx;
        sy = cy;
        unique case (r_screen_mode)
            pfms_pkg::MODE_STRETCH_X: begin
                sx = cx >> 1;
            end
            pfms_pkg::MODE_STRETCH_Y: begin
                sy = cy >> 1;
            end
            pfms_pkg::MODE_STRETCH_XY: begin
                sx = cx >> 1;
                sy = cy >> 1;
            end
            pfms_pkg::MODE_MIRROR_X: begin
                sx = mirror_coord(cx);
            end
            pfms_pkg::MODE_MIRROR_Y: begin
                sy = mirror_coord(cy);
            end
            pfms_pkg::MODE_MIRROR_XY: begin
                sx = mirror_coord(cx);
                sy = mirror_coord(cy);
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = AW'(AW'(sy) * AW'(HALF)) + AW'(sx >> 1);
    assign wr_addr = AW'(i_byte_addr);

    // cmd layout: {op, addr, data, high nibble}
    always_comb begin
        if (i_mode == pfms_pkg::OP_WRITE) begin
            n_cmd = {pfms_pkg::OP_WRITE, wr_addr, i_byte_data, 1'b0};
        end else begin
            n_cmd = {pfms_pkg::OP_READ, rd_addr, {pfms_pkg::DATA_W{1'b0}}, sx[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_mode <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_screen_mode <= i_cfg_data;
            end
            if (advance) begin
                // out-of-range writes are dropped here
                r_valid <= accept && ((i_mode == pfms_pkg::OP_READ) || wr_ok);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;

    a_busy_holds_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> r_valid)
        else $error("front dropped a stalled beat");

    a_stall_keeps_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_push_ready) |=> $stable(r_cmd))
        else $error("front command changed under stall");

endmodule

`default_nettype wire

>>> rtl/pfms_queue.sv
// Short FIFO between front and back ends.
// Depends on pfms_pkg for its depth.
`default_nettype none

module pfms_queue #(
    parameter int PW = 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push_valid,
    input  wire  [PW-1:0] i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output logic [PW-1:0] o_pop_data
);

    localparam int DEPTH = pfms_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PW-1:0]    r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic push, pop;

    assign o_push_ready = r_count != FULL_CNT;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count overflow");

endmodule

`default_nettype wire

>>> rtl/pfms_back.sv
// Back end: frame memory, packed byte writes and pixel reads with nibble pick.
// Depends on pfms_pkg.
`default_nettype none

module pfms_back #(
    parameter int FRAME_SIDE = pfms_pkg::FRAME_SIDE_DEF,
    parameter int AW         = $clog2(FRAME_SIDE * (FRAME_SIDE / 2)),
    parameter int PW         = AW + pfms_pkg::DATA_W + 2
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_pop_valid,
    input  wire  [PW-1:0]                    i_pop_data,
    output logic                             o_done,
    output logic [pfms_pkg::INDEX_W-1:0]     o_pixel_index
);

    localparam int DEPTH = FRAME_SIDE * (FRAME_SIDE / 2);

    logic [pfms_pkg::DATA_W-1:0] r_frame [DEPTH];
    logic [pfms_pkg::DATA_W-1:0] r_rd_data;
    logic                        r_rd_valid;
    logic                        r_hi;

    logic                        op;
    logic [AW-1:0]               addr;
    logic [pfms_pkg::DATA_W-1:0] data;
    logic                        hi;

    assign {op, addr, data, hi} = i_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_pop_valid && (op == pfms_pkg::OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid) begin
            if (op == pfms_pkg::OP_WRITE) begin
                r_frame[addr] <= data;
            end else begin
                r_rd_data <= r_frame[addr];
                r_hi      <= hi;
            end
        end
    end

    assign o_done        = r_rd_valid;
    assign o_pixel_index = r_hi ? r_rd_data[7:4] : r_rd_data[3:0];

    a_done_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop_valid && (op == pfms_pkg::OP_READ)) |=> o_done)
        else $error("read beat gave no result");

    a_no_done_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop_valid && (op == pfms_pkg::OP_READ)) |=> !o_done)
        else $error("result without read beat");

endmodule

`default_nettype wire

>>> rtl/packed_frame_mode_scanout.sv
// Top level of the packed frame scan-out block.
// Instantiates pfms_front, pfms_queue and pfms_back; depends on pfms_pkg.
//
// Takes one command beat per clock (start high, busy low): a write stores one
// packed byte (low nibble left pixel), a read returns one 4-bit color index
// under the current screen mode. A read result shows on o_pixel_index with
// o_done high for exactly one cycle, after the front, queue and back registers;
// results come back in command order and cannot be held off. Sustained rate
// is one beat per clock, set by the single port of the frame memory, which
// serves one write or one read each cycle; busy rises only if the queue
// between the front end and the memory fills. Write screen_mode only while idle.
`default_nettype none

module packed_frame_mode_scanout #(
    parameter int FRAME_SIDE = pfms_pkg::FRAME_SIDE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_mode,
    input  wire  [pfms_pkg::ADDR_W-1:0]      i_byte_addr,
    input  wire  [pfms_pkg::DATA_W-1:0]      i_byte_data,
    input  wire  [pfms_pkg::PIX_W-1:0]       i_pixel_x,
    input  wire  [pfms_pkg::PIX_W-1:0]       i_pixel_y,
    input  wire                              i_cfg_we,
    input  wire  [pfms_pkg::MODE_W-1:0]      i_cfg_data,
    output logic                             o_done,
    output logic [pfms_pkg::INDEX_W-1:0]     o_pixel_index
);

    localparam int AW = $clog2(FRAME_SIDE * (FRAME_SIDE / 2));
    localparam int PW = AW + pfms_pkg::DATA_W + 2;

    logic          push_valid;
    logic [PW-1:0] push_data;
    logic          push_ready;
    logic          pop_valid;
    logic [PW-1:0] pop_data;

    pfms_front #(
        .FRAME_SIDE (FRAME_SIDE),
        .AW         (AW),
        .PW         (PW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_mode       (i_mode),
        .i_byte_addr  (i_byte_addr),
        .i_byte_data  (i_byte_data),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    pfms_queue #(
        .PW (PW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data)
    );

    pfms_back #(
        .FRAME_SIDE (FRAME_SIDE),
        .AW         (AW),
        .PW         (PW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .i_pop_data    (pop_data),
        .o_done        (o_done),
        .o_pixel_index (o_pixel_index)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for packed_frame_mode_scanout: random pixel writes and reads
// under every screen mode, with a predictor of the frame contents updated per accepted beat.
// Depends on pfms_pkg and the packed_frame_mode_scanout RTL.
`timescale 1ns / 1ps

module tb;

    localparam int ADDR_W      = pfms_pkg::ADDR_W;
    localparam int DATA_W      = pfms_pkg::DATA_W;
    localparam int PIX_W       = pfms_pkg::PIX_W;
    localparam int INDEX_W     = pfms_pkg::INDEX_W;
    localparam int MODE_W      = pfms_pkg::MODE_W;
    localparam int STORE_DEPTH = 8192;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
    } t_scan_cmd;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_mode;
    logic [ADDR_W-1:0]   i_byte_addr;
    logic [DATA_W-1:0]   i_byte_data;
    logic [PIX_W-1:0]    i_pixel_x;
    logic [PIX_W-1:0]    i_pixel_y;
    logic                i_cfg_we;
    logic [MODE_W-1:0]   i_cfg_data;
    logic                o_done;
    logic [INDEX_W-1:0]  o_pixel_index;

    packed_frame_mode_scanout u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_byte_addr   (i_byte_addr),
        .i_byte_data   (i_byte_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_pixel_index (o_pixel_index)
    );

    t_scan_cmd           cmd_q[$];
    logic [INDEX_W-1:0]  pixel_exp_q[$];
    logic [DATA_W-1:0]   frame_copy [STORE_DEPTH];
    bit                  gen_written [STORE_DEPTH];
    logic [MODE_W-1:0]   active_mode;
    logic [MODE_W-1:0]   gen_mode;
    t_scan_cmd           drv_cmd;
    int                  gap_left;
    bit                  idle_on;
    bit                  accepted;
    int                  fail_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // {byte address, high nibble select} of the stored pixel shown at (x, y)
    function automatic logic [ADDR_W:0] pixel_source(input logic [MODE_W-1:0] m,
                                                     input logic [PIX_W-1:0] x,
                                                     input logic [PIX_W-1:0] y);
        logic [PIX_W-1:0] sx;
        logic [PIX_W-1:0] sy;
        sx = x;
        sy = y;
        case (m)
            pfms_pkg::MODE_STRETCH_X: sx = x >> 1;
            pfms_pkg::MODE_STRETCH_Y: sy = y >> 1;
            pfms_pkg::MODE_STRETCH_XY: begin
                sx = x >> 1;
                sy = y >> 1;
            end
            pfms_pkg::MODE_MIRROR_X: sx = x[PIX_W-1] ? 7'd127 - x : x;
            pfms_pkg::MODE_MIRROR_Y: sy = y[PIX_W-1] ? 7'd127 - y : y;
            pfms_pkg::MODE_MIRROR_XY: begin
                sx = x[PIX_W-1] ? 7'd127 - x : x;
                sy = y[PIX_W-1] ? 7'd127 - y : y;
            end
            default: ;
        endcase
        return {sy, sx[PIX_W-1:1], sx[0]};
    endfunction

    task automatic apply_beat(input t_scan_cmd c);
        logic [ADDR_W:0]    src;
        logic [DATA_W-1:0]  b;
        if (c.op == pfms_pkg::OP_WRITE) begin
            frame_copy[c.addr] = c.data;
        end else begin
            src = pixel_source(active_mode, c.px, c.py);
            b = frame_copy[src[ADDR_W:1]];
            pixel_exp_q.push_back(src[0] ? b[7:4] : b[3:0]);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            accepted = start && !busy;
            if (accepted) apply_beat(drv_cmd);
            if (start && !accepted) begin
            end else if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                drv_cmd = cmd_q.pop_front();
                i_mode      <= drv_cmd.op;
                i_byte_addr <= drv_cmd.addr;
                i_byte_data <= drv_cmd.data;
                i_pixel_x   <= drv_cmd.px;
                i_pixel_y   <= drv_cmd.py;
                start       <= 1'b1;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pixel_exp_q.size() == 0) begin
                $error("pixel_index: unexpected beat, expected none, actual %0h",
                       o_pixel_index);
                fail_count++;
            end else begin
                logic [INDEX_W-1:0] exp_pix;
                exp_pix = pixel_exp_q.pop_front();
                if (o_pixel_index !== exp_pix) begin
                    $error("pixel_index mismatch: expected %0h, actual %0h",
                           exp_pix, o_pixel_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_write(input int addr, input int data);
        t_scan_cmd c;
        c.op   = pfms_pkg::OP_WRITE;
        c.addr = ADDR_W'(addr);
        c.data = DATA_W'(data);
        c.px   = PIX_W'($urandom);
        c.py   = PIX_W'($urandom);
        gen_written[addr] = 1'b1;
        cmd_q.push_back(c);
    endtask

    task automatic push_read(input int x, input int y);
        t_scan_cmd c;
        c.op   = pfms_pkg::OP_READ;
        c.addr = ADDR_W'($urandom);
        c.data = DATA_W'($urandom);
        c.px   = PIX_W'(x);
        c.py   = PIX_W'(y);
        cmd_q.push_back(c);
    endtask

    // read (x, y); first write its source byte if it was never written
    task automatic add_read(input int x, input int y, inout int count);
        logic [ADDR_W:0] src;
        src = pixel_source(gen_mode, PIX_W'(x), PIX_W'(y));
        if (!gen_written[src[ADDR_W:1]]) begin
            push_write(int'(src[ADDR_W:1]), $urandom_range(0, 255));
            count++;
        end
        push_read(x, y);
        count++;
    endtask

    function automatic int pick_coord();
        int r;
        int corners[4] = '{0, 63, 64, 127};
        r = $urandom_range(0, 99);
        if (r < 20) return corners[$urandom_range(0, 3)];
        if (r < 55) return $urandom_range(0, 15);
        return $urandom_range(0, 127);
    endfunction

    task automatic fill_phase(input int n);
        int count;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 99) < 12) begin
                push_write($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255));
                count++;
            end else begin
                add_read(pick_coord(), pick_coord(), count);
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || pixel_exp_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_screen_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= MODE_W'($urandom);
        active_mode = m;
        gen_mode    = m;
    endtask

    initial begin
        logic [MODE_W-1:0] modes[11];
        fail_count  = 0;
        active_mode = '0;
        gen_mode    = '0;
        idle_on     = 1'b1;
        gap_left    = 0;
        i_rst_n     = 1'b0;
        start       <= 1'b0;
        i_mode      <= pfms_pkg::OP_WRITE;
        i_byte_addr <= '0;
        i_byte_data <= '0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, nibble extremes, overwrite followed by read-back
        push_write(0, 8'hF0);
        push_write(STORE_DEPTH - 1, 8'h0F);
        push_write(63, 8'hFF);
        push_write(STORE_DEPTH - 64, 8'h00);
        push_read(0, 0);
        push_read(1, 0);
        push_read(127, 127);
        push_read(126, 127);
        push_read(127, 0);
        push_read(0, 127);
        push_write(0, 8'h3C);
        push_read(0, 0);
        push_read(1, 0);
        push_read(126, 0);
        fill_phase(100);
        wait_drained();

        modes = '{pfms_pkg::MODE_STRETCH_X, pfms_pkg::MODE_STRETCH_Y,
                  pfms_pkg::MODE_STRETCH_XY, 8'd4, pfms_pkg::MODE_MIRROR_X,
                  pfms_pkg::MODE_MIRROR_Y, pfms_pkg::MODE_MIRROR_XY, 8'd255, 8'd0,
                  MODE_W'($urandom_range(8, 254)), pfms_pkg::MODE_MIRROR_XY};
        for (int p = 0; p < 11; p++) begin
            idle_on = (p % 3 != 2);
            set_screen_mode(modes[p]);
            fill_phase(122);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
